[hw/rtl/vha_pkg.sv]
`timescale 1ns / 1ps

package vha_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int LANES         = 3;
  localparam int ROOT_W        = 32;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_DOT    = 3'd2,
    OP_CROSS  = 3'd3,
    OP_EQUAL  = 3'd4,
    OP_LENGTH = 3'd5,
    OP_NORM   = 3'd6,
    OP_DEHOM  = 3'd7
  } op_e;

  typedef logic signed [DATA_W-1:0] fix_t;
  typedef logic [DATA_W-1:0]        mag_t;

  typedef struct packed {
    op_e  op;
    fix_t a_x;
    fix_t a_y;
    fix_t a_z;
    fix_t a_w;
    fix_t b_x;
    fix_t b_y;
    fix_t b_z;
  } req_t;

  typedef struct packed {
    fix_t r_x;
    fix_t r_y;
    fix_t r_z;
    fix_t r_scalar;
    logic is_equal;
    logic fault;
  } rsp_t;

endpackage

[hw/rtl/vha_div.sv]
`timescale 1ns / 1ps

module vha_div
  import vha_pkg::*;
#(
  parameter int NW = DATA_W + FRAC_BITS_DEF,
  parameter int DW = DATA_W,
  parameter int QW = DATA_W + FRAC_BITS_DEF,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] num [LANES],
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] side,
  output logic          out_valid,
  output logic [QW-1:0] quo [LANES],
  output logic [SW-1:0] side_out
);

  logic          vld      [QW];
  logic [DW-1:0] dv       [QW];
  logic [SW-1:0] sd       [QW];
  logic [DW-1:0] rem      [QW][LANES];
  logic [QW-1:0] lq       [QW][LANES];
  logic [DW-1:0] src_dv   [QW];
  logic [DW-1:0] src_rem  [QW][LANES];
  logic [QW-1:0] src_lq   [QW][LANES];
  logic [DW-1:0] rem_next [QW][LANES];
  logic [QW-1:0] lq_next  [QW][LANES];

  // Stage zero starts from the high numerator bits, which stay below the divisor
  always_comb begin
    src_dv[0] = den;
    for (int l = 0; l < LANES; l++) begin
      src_rem[0][l] = DW'(num[l] >> QW);
      src_lq[0][l]  = QW'(num[l]);
    end
    for (int k = 1; k < QW; k++) begin
      src_dv[k] = dv[k-1];
      for (int l = 0; l < LANES; l++) begin
        src_rem[k][l] = rem[k-1][l];
        src_lq[k][l]  = lq[k-1][l];
      end
    end
  end

  // One restoring step per stage: numerator bits leave at the top, quotient bits enter below
  always_comb begin
    logic [DW:0] t;
    t = '0;
    for (int k = 0; k < QW; k++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {src_rem[k][l], src_lq[k][l][QW-1]};
        if (t >= {1'b0, src_dv[k]}) begin
          rem_next[k][l] = DW'(t - {1'b0, src_dv[k]});
          lq_next[k][l]  = {src_lq[k][l][QW-2:0], 1'b1};
        end else begin
          rem_next[k][l] = t[DW-1:0];
          lq_next[k][l]  = {src_lq[k][l][QW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < QW; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side;
      for (int k = 1; k < QW; k++) sd[k] <= sd[k-1];
      for (int k = 0; k < QW; k++) begin
        dv[k] <= src_dv[k];
        for (int l = 0; l < LANES; l++) begin
          rem[k][l] <= rem_next[k][l];
          lq[k][l]  <= lq_next[k][l];
        end
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign side_out  = sd[QW-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) quo[l] = lq[QW-1][l];
  end

endmodule

[hw/rtl/vha_isqrt.sv]
`timescale 1ns / 1ps

module vha_isqrt
  import vha_pkg::*;
#(
  parameter int RW = ROOT_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side,
  output logic            out_valid,
  output logic [RW-1:0]   root,
  output logic [SW-1:0]   side_out
);

  logic            vld      [RW];
  logic [SW-1:0]   sd       [RW];
  logic [RW+1:0]   rem      [RW];
  logic [RW-1:0]   rt       [RW];
  logic [2*RW-1:0] nl       [RW];
  logic [RW+1:0]   src_rem  [RW];
  logic [RW-1:0]   src_rt   [RW];
  logic [2*RW-1:0] src_nl   [RW];
  logic [RW+1:0]   rem_next [RW];
  logic [RW-1:0]   rt_next  [RW];

  always_comb begin
    src_rem[0] = '0;
    src_rt[0]  = '0;
    src_nl[0]  = rad;
    for (int k = 1; k < RW; k++) begin
      src_rem[k] = rem[k-1];
      src_rt[k]  = rt[k-1];
      src_nl[k]  = nl[k-1];
    end
  end

  // Bring down two radicand bits per stage and try the next root bit
  always_comb begin
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    t     = '0;
    trial = '0;
    for (int k = 0; k < RW; k++) begin
      t     = {src_rem[k], src_nl[k][2*RW-1 -: 2]};
      trial = (RW+4)'({src_rt[k], 2'b01});
      if (t >= trial) begin
        rem_next[k] = (RW+2)'(t - trial);
        rt_next[k]  = {src_rt[k][RW-2:0], 1'b1};
      end else begin
        rem_next[k] = t[RW+1:0];
        rt_next[k]  = {src_rt[k][RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < RW; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < RW; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= side;
      for (int k = 1; k < RW; k++) sd[k] <= sd[k-1];
      for (int k = 0; k < RW; k++) begin
        rem[k] <= rem_next[k];
        rt[k]  <= rt_next[k];
        nl[k]  <= src_nl[k] << 2;
      end
    end
  end

  assign out_valid = vld[RW-1];
  assign root      = rt[RW-1];
  assign side_out  = sd[RW-1];

endmodule

[hw/rtl/vec3_homogeneous_alu_unit.sv]
// Throughput: one transaction per cycle while the output buffer has room; every op takes
// the same path length.
// Depth is set by the two restoring dividers (one quotient bit per stage) and the
// 32-stage square root; a two-entry output buffer absorbs response stalls.
// Reset clears the stage valid bits and the output buffer; datapath registers are not reset.
`timescale 1ns / 1ps

module vec3_homogeneous_alu_unit
  import vha_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req_data,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp_data
);

  localparam int NUM_W  = DATA_W + FRAC_BITS;
  localparam int Q1_W   = DATA_W + FRAC_BITS;
  localparam int Q2_W   = FRAC_BITS + 1;
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int NMUL   = 2 * LANES;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_BITS - 1);
  localparam fix_t FIX_MAX = fix_t'({1'b0, {(DATA_W-1){1'b1}}});
  localparam fix_t FIX_MIN = fix_t'({1'b1, {(DATA_W-1){1'b0}}});
  localparam logic [Q1_W-1:0] Q1_POS = Q1_W'({1'b0, {(DATA_W-1){1'b1}}});
  localparam logic [Q1_W-1:0] Q1_NEG = Q1_W'({1'b1, {(DATA_W-1){1'b0}}});

  typedef struct packed {
    op_e              op;
    rsp_t             early;
    logic             w_zero;
    logic [LANES-1:0] q_neg;
  } side1_t;

  typedef struct packed {
    op_e                    op;
    rsp_t                   early;
    logic                   w_zero;
    logic                   c_fault;
    fix_t [LANES-1:0]       c;
  } side2_t;

  typedef struct packed {
    side2_t s;
    mag_t   len;
  } side3_t;

  logic en;
  logic [1:0] cnt;

  assign en        = (cnt != 2'd2);
  assign req_ready = en;

  // ---------------- stage 1: products, add/sub, compare, magnitudes
  fix_t a_in [LANES];
  fix_t b_in [LANES];
  fix_t mul_a [NMUL];
  fix_t mul_b [NMUL];

  assign a_in[0] = req_data.a_x;
  assign a_in[1] = req_data.a_y;
  assign a_in[2] = req_data.a_z;
  assign b_in[0] = req_data.b_x;
  assign b_in[1] = req_data.b_y;
  assign b_in[2] = req_data.b_z;

  // Cross pairs the products for each component; dot uses the even slots
  always_comb begin
    if (req_data.op == OP_CROSS) begin
      mul_a[0] = req_data.a_y; mul_b[0] = req_data.b_z;
      mul_a[1] = req_data.a_z; mul_b[1] = req_data.b_y;
      mul_a[2] = req_data.a_z; mul_b[2] = req_data.b_x;
      mul_a[3] = req_data.a_x; mul_b[3] = req_data.b_z;
      mul_a[4] = req_data.a_x; mul_b[4] = req_data.b_y;
      mul_a[5] = req_data.a_y; mul_b[5] = req_data.b_x;
    end else begin
      mul_a[0] = req_data.a_x; mul_b[0] = req_data.b_x;
      mul_a[1] = '0;           mul_b[1] = '0;
      mul_a[2] = req_data.a_y; mul_b[2] = req_data.b_y;
      mul_a[3] = '0;           mul_b[3] = '0;
      mul_a[4] = req_data.a_z; mul_b[4] = req_data.b_z;
      mul_a[5] = '0;           mul_b[5] = '0;
    end
  end

  logic                     s1_v;
  op_e                      s1_op;
  logic                     s1_eq;
  logic signed [DATA_W:0]   s1_as   [LANES];
  logic signed [PROD_W-1:0] s1_m    [NMUL];
  mag_t                     s1_amag [LANES];
  logic [LANES-1:0]         s1_aneg;
  mag_t                     s1_wmag;
  logic                     s1_wneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= req_data.op;
      s1_eq <= (req_data.a_x == req_data.b_x) && (req_data.a_y == req_data.b_y) &&
               (req_data.a_z == req_data.b_z);
      for (int i = 0; i < NMUL; i++) s1_m[i] <= mul_a[i] * mul_b[i];
      for (int l = 0; l < LANES; l++) begin
        if (req_data.op == OP_SUB) begin
          s1_as[l] <= (DATA_W+1)'(a_in[l]) - (DATA_W+1)'(b_in[l]);
        end else begin
          s1_as[l] <= (DATA_W+1)'(a_in[l]) + (DATA_W+1)'(b_in[l]);
        end
        s1_amag[l] <= a_in[l][DATA_W-1] ? mag_t'(-a_in[l]) : mag_t'(a_in[l]);
        s1_aneg[l] <= a_in[l][DATA_W-1];
      end
      s1_wmag <= req_data.a_w[DATA_W-1] ? mag_t'(-req_data.a_w) : mag_t'(req_data.a_w);
      s1_wneg <= req_data.a_w[DATA_W-1];
    end
  end

  // ---------------- stage 2: product sums with round half up, add/sub clamp
  logic signed [ACC_W-1:0] acc [LANES];
  logic                    as_flt;

  always_comb begin
    if (s1_op == OP_DOT) begin
      acc[0] = ACC_W'(s1_m[0]) + ACC_W'(s1_m[2]) + ACC_W'(s1_m[4]);
      acc[1] = '0;
      acc[2] = '0;
    end else begin
      for (int l = 0; l < LANES; l++) begin
        acc[l] = ACC_W'(s1_m[2*l]) - ACC_W'(s1_m[2*l+1]);
      end
    end
  end

  always_comb begin
    as_flt = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (s1_as[l][DATA_W] != s1_as[l][DATA_W-1]) as_flt = 1'b1;
    end
  end

  logic                    s2_v;
  op_e                     s2_op;
  logic                    s2_eq;
  fix_t                    s2_as    [LANES];
  logic                    s2_as_flt;
  logic signed [ACC_W-1:0] s2_rnd   [LANES];
  mag_t                    s2_amag  [LANES];
  logic [LANES-1:0]        s2_aneg;
  mag_t                    s2_wmag;
  logic                    s2_wneg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_op     <= s1_op;
      s2_eq     <= s1_eq;
      s2_as_flt <= as_flt;
      for (int l = 0; l < LANES; l++) begin
        s2_rnd[l] <= (acc[l] + HALF) >>> FRAC_BITS;
        if (s1_as[l][DATA_W] == s1_as[l][DATA_W-1]) begin
          s2_as[l] <= fix_t'(s1_as[l][DATA_W-1:0]);
        end else begin
          s2_as[l] <= s1_as[l][DATA_W] ? FIX_MIN : FIX_MAX;
        end
      end
      s2_amag <= s1_amag;
      s2_aneg <= s1_aneg;
      s2_wmag <= s1_wmag;
      s2_wneg <= s1_wneg;
    end
  end

  // ---------------- stage 3: clamp dot/cross, assemble direct results
  fix_t rnd_sat [LANES];
  logic [LANES-1:0] rnd_flt;
  rsp_t early;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if ((&s2_rnd[l][ACC_W-1:DATA_W-1]) || !(|s2_rnd[l][ACC_W-1:DATA_W-1])) begin
        rnd_sat[l] = fix_t'(s2_rnd[l][DATA_W-1:0]);
        rnd_flt[l] = 1'b0;
      end else begin
        rnd_sat[l] = s2_rnd[l][ACC_W-1] ? FIX_MIN : FIX_MAX;
        rnd_flt[l] = 1'b1;
      end
    end
  end

  always_comb begin
    early = '0;
    unique case (s2_op) inside
      OP_ADD, OP_SUB: begin
        early.r_x   = s2_as[0];
        early.r_y   = s2_as[1];
        early.r_z   = s2_as[2];
        early.fault = s2_as_flt;
      end
      OP_DOT: begin
        early.r_scalar = rnd_sat[0];
        early.fault    = rnd_flt[0];
      end
      OP_CROSS: begin
        early.r_x   = rnd_sat[0];
        early.r_y   = rnd_sat[1];
        early.r_z   = rnd_sat[2];
        early.fault = |rnd_flt;
      end
      OP_EQUAL: begin
        early.is_equal = s2_eq;
      end
      default: begin
        early = '0;
      end
    endcase
  end

  logic             s3_v;
  side1_t           s3_side;
  mag_t             s3_wmag;
  logic [NUM_W-1:0] s3_num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_side.op     <= s2_op;
      s3_side.early  <= early;
      s3_side.w_zero <= (s2_wmag == '0);
      s3_side.q_neg  <= s2_aneg ^ {LANES{s2_wneg}};
      s3_wmag        <= s2_wmag;
      for (int l = 0; l < LANES; l++) s3_num[l] <= {s2_amag[l], {FRAC_BITS{1'b0}}};
    end
  end

  // ---------------- perspective divide
  logic            d1_v;
  logic [Q1_W-1:0] d1_q [LANES];
  side1_t          d1_side;

  vha_div #(
    .NW (NUM_W),
    .DW (DATA_W),
    .QW (Q1_W),
    .SW ($bits(side1_t))
  ) u_div_w (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s3_v),
    .num       (s3_num),
    .den       (s3_wmag),
    .side      (s3_side),
    .out_valid (d1_v),
    .quo       (d1_q),
    .side_out  (d1_side)
  );

  // ---------------- stage 4: sign and clamp the divided components
  fix_t             c_val [LANES];
  logic [LANES-1:0] c_flt;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (d1_side.q_neg[l]) begin
        c_flt[l] = (d1_q[l] > Q1_NEG);
        c_val[l] = c_flt[l] ? FIX_MIN : fix_t'(-d1_q[l][DATA_W-1:0]);
      end else begin
        c_flt[l] = (d1_q[l] > Q1_POS);
        c_val[l] = c_flt[l] ? FIX_MAX : fix_t'(d1_q[l][DATA_W-1:0]);
      end
    end
  end

  logic   s4_v;
  side1_t s4_side;
  fix_t   s4_c [LANES];
  logic   s4_cflt;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_side <= d1_side;
      s4_c    <= c_val;
      s4_cflt <= |c_flt;
    end
  end

  // ---------------- stages 5 and 6: squares and their sum
  logic              s5_v;
  side1_t            s5_side;
  fix_t              s5_c  [LANES];
  logic              s5_cflt;
  logic [PROD_W-1:0] s5_sq [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_v <= 1'b0;
    end else if (en) begin
      s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_side <= s4_side;
      s5_c    <= s4_c;
      s5_cflt <= s4_cflt;
      for (int l = 0; l < LANES; l++) s5_sq[l] <= PROD_W'(s4_c[l]) * PROD_W'(s4_c[l]);
    end
  end

  logic              s6_v;
  side2_t            s6_side;
  logic [PROD_W-1:0] s6_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_v <= 1'b0;
    end else if (en) begin
      s6_v <= s5_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_sum            <= s5_sq[0] + s5_sq[1] + s5_sq[2];
      s6_side.op        <= s5_side.op;
      s6_side.early     <= s5_side.early;
      s6_side.w_zero    <= s5_side.w_zero;
      s6_side.c_fault   <= s5_cflt;
      for (int l = 0; l < LANES; l++) s6_side.c[l] <= s5_c[l];
    end
  end

  // ---------------- length
  logic            sq_v;
  logic [ROOT_W-1:0] sq_root;
  side2_t          sq_side;

  vha_isqrt #(
    .RW (ROOT_W),
    .SW ($bits(side2_t))
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_v),
    .rad       (s6_sum),
    .side      (s6_side),
    .out_valid (sq_v),
    .root      (sq_root),
    .side_out  (sq_side)
  );

  // ---------------- stage 7: normalise operands
  logic             s7_v;
  side3_t           s7_side;
  logic [NUM_W-1:0] s7_num [LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_v <= 1'b0;
    end else if (en) begin
      s7_v <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_side.s   <= sq_side;
      s7_side.len <= mag_t'(sq_root);
      for (int l = 0; l < LANES; l++) begin
        s7_num[l] <= {(sq_side.c[l][DATA_W-1] ? mag_t'(-sq_side.c[l]) : mag_t'(sq_side.c[l])),
                      {FRAC_BITS{1'b0}}};
      end
    end
  end

  // ---------------- normalise divide
  logic            d2_v;
  logic [Q2_W-1:0] d2_q [LANES];
  side3_t          d2_side;

  vha_div #(
    .NW (NUM_W),
    .DW (DATA_W),
    .QW (Q2_W),
    .SW ($bits(side3_t))
  ) u_div_len (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s7_v),
    .num       (s7_num),
    .den       (s7_side.len),
    .side      (s7_side),
    .out_valid (d2_v),
    .quo       (d2_q),
    .side_out  (d2_side)
  );

  // ---------------- stage 8: final select
  fix_t nq [LANES];
  rsp_t fin;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      nq[l] = d2_side.s.c[l][DATA_W-1] ? fix_t'(-DATA_W'(d2_q[l])) : fix_t'(DATA_W'(d2_q[l]));
    end
  end

  always_comb begin
    fin = '0;
    unique case (d2_side.s.op) inside
      OP_ADD, OP_SUB, OP_DOT, OP_CROSS, OP_EQUAL: begin
        fin = d2_side.s.early;
      end
      default: begin
        if (d2_side.s.w_zero) begin
          fin.fault = 1'b1;
        end else if (d2_side.s.op == OP_DEHOM) begin
          fin.r_x   = d2_side.s.c[0];
          fin.r_y   = d2_side.s.c[1];
          fin.r_z   = d2_side.s.c[2];
          fin.fault = d2_side.s.c_fault;
        end else if (d2_side.s.op == OP_LENGTH) begin
          fin.r_scalar = d2_side.len[DATA_W-1] ? FIX_MAX : fix_t'(d2_side.len);
          fin.fault    = d2_side.s.c_fault | d2_side.len[DATA_W-1];
        end else if (d2_side.len == '0) begin
          fin.fault = 1'b1;
        end else begin
          fin.r_x   = nq[0];
          fin.r_y   = nq[1];
          fin.r_z   = nq[2];
          fin.fault = d2_side.s.c_fault;
        end
      end
    endcase
  end

  logic s8_v;
  rsp_t s8_rsp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_v <= 1'b0;
    end else if (en) begin
      s8_v <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) s8_rsp <= fin;
  end

  // ---------------- output buffer: two entries; the pipe stalls only once both are full
  rsp_t ob_data [2];
  logic wp;
  logic rp;
  logic push;
  logic pop;

  assign push      = s8_v && en;
  assign pop       = rsp_valid && rsp_ready;
  assign rsp_valid = (cnt != 2'd0);
  assign rsp_data  = ob_data[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) ob_data[wp] <= s8_rsp;
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import vha_pkg::*;

  localparam int FB = 16;

  class vec_scoreboard;
    rsp_t expected_q[$];
    int   mismatches = 0;
    bit   sat_hit;

    function fix_t clamp(logic signed [95:0] v);
      if (v > 96'sd2147483647) begin
        sat_hit = 1;
        return 32'h7fffffff;
      end
      if (v < -96'sd2147483648) begin
        sat_hit = 1;
        return 32'h80000000;
      end
      return v[31:0];
    endfunction

    // round half up: add one half, then floor
    function logic signed [95:0] round_sum(longint p1, longint p2, longint p3);
      logic signed [95:0] acc;
      acc = p1;
      acc = acc + p2 + p3 + (96'sd1 <<< (FB - 1));
      return acc >>> FB;
    endfunction

    function longint unsigned root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function rsp_t compute(req_t q);
      rsp_t e;
      longint ax, ay, az, aw, bx, by, bz;
      longint c[3];
      longint unsigned s, len;
      ax = q.a_x; ay = q.a_y; az = q.a_z; aw = q.a_w;
      bx = q.b_x; by = q.b_y; bz = q.b_z;
      e = '0;
      sat_hit = 0;
      case (q.op)
        OP_ADD: begin
          e.r_x = clamp(ax + bx);
          e.r_y = clamp(ay + by);
          e.r_z = clamp(az + bz);
        end
        OP_SUB: begin
          e.r_x = clamp(ax - bx);
          e.r_y = clamp(ay - by);
          e.r_z = clamp(az - bz);
        end
        OP_DOT: e.r_scalar = clamp(round_sum(ax * bx, ay * by, az * bz));
        OP_CROSS: begin
          e.r_x = clamp(round_sum(ay * bz, az * (-by), 0));
          e.r_y = clamp(round_sum(az * bx, ax * (-bz), 0));
          e.r_z = clamp(round_sum(ax * by, ay * (-bx), 0));
        end
        OP_EQUAL: e.is_equal = (ax == bx) && (ay == by) && (az == bz);
        default: begin
          if (aw == 0) begin
            sat_hit = 1;
          end else begin
            c[0] = clamp((ax <<< FB) / aw);
            c[1] = clamp((ay <<< FB) / aw);
            c[2] = clamp((az <<< FB) / aw);
            if (q.op == OP_DEHOM) begin
              e.r_x = c[0]; e.r_y = c[1]; e.r_z = c[2];
            end else begin
              s = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
              len = root(s);
              if (q.op == OP_LENGTH) begin
                e.r_scalar = clamp({32'd0, len});
              end else if (len == 0) begin
                sat_hit = 1;
              end else begin
                e.r_x = clamp((c[0] <<< FB) / longint'(len));
                e.r_y = clamp((c[1] <<< FB) / longint'(len));
                e.r_z = clamp((c[2] <<< FB) / longint'(len));
              end
            end
          end
        end
      endcase
      e.fault = sat_hit;
      return e;
    endfunction

    function void note_request(req_t q);
      expected_q.push_back(compute(q));
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
        return;
      end
      e = expected_q.pop_front();
      if (got !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp x=%h y=%h z=%h s=%h eq=%b f=%b / got x=%h y=%h z=%h s=%h eq=%b f=%b",
                   e.r_x, e.r_y, e.r_z, e.r_scalar, e.is_equal, e.fault,
                   got.r_x, got.r_y, got.r_z, got.r_scalar, got.is_equal, got.fault);
      end
    endfunction
  endclass

  logic clk, rst, req_valid, req_ready, rsp_valid, rsp_ready;
  req_t req_data;
  rsp_t rsp_data;

  vec_scoreboard sb;
  int send_idle_pct, recv_idle_pct, recv_hold;

  vec3_homogeneous_alu_unit u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
    .req_data(req_data), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .rsp_data(rsp_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // response side: check each transaction, stall at random or for a hold-off
  initial begin
    rsp_ready = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) sb.check_response(rsp_data);
      if (recv_hold > 0) begin
        recv_hold--;
        rsp_ready <= 0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic send_vec(req_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 0;
      @(posedge clk);
    end
    req_data  <= q;
    req_valid <= 1;
    do @(posedge clk); while (!req_ready);
    sb.note_request(q);
  endtask

  function automatic fix_t rand_fix();
    case ($urandom_range(3))
      0: return $urandom;
      1: return fix_t'($signed($urandom_range(32'h7ffff)) - 32'sh40000);
      2: return fix_t'($signed($urandom_range(32'h1ff)) - 32'sh100);
      default: return fix_t'($signed($urandom_range(32'h1ffffff)) - 32'sh1000000);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.op  = op_e'($urandom_range(7));
    q.a_x = rand_fix(); q.a_y = rand_fix(); q.a_z = rand_fix();
    case ($urandom_range(5))
      0: q.a_w = 0;
      1: q.a_w = $urandom;
      default: q.a_w = fix_t'($signed($urandom_range(32'h3ffff)) - 32'sh20000);
    endcase
    q.b_x = rand_fix(); q.b_y = rand_fix(); q.b_z = rand_fix();
    if ($urandom_range(7) == 0) begin
      q.b_x = q.a_x; q.b_y = q.a_y;
      q.b_z = $urandom_range(1) ? q.a_z : q.a_z + 1;
    end
    return q;
  endfunction

  function automatic req_t mk(op_e op, fix_t ax, fix_t ay, fix_t az, fix_t aw,
                              fix_t bx, fix_t by, fix_t bz);
    req_t q;
    q.op = op; q.a_x = ax; q.a_y = ay; q.a_z = az; q.a_w = aw;
    q.b_x = bx; q.b_y = by; q.b_z = bz;
    return q;
  endfunction

  localparam fix_t MAXV = 32'h7fffffff;
  localparam fix_t MINV = 32'h80000000;
  localparam fix_t ONE  = 32'h00010000;

  initial begin
    req_t dir_q[$];
    sb = new();
    rst = 1; req_valid = 0; req_data = '0;
    send_idle_pct = 0; recv_idle_pct = 0; recv_hold = 0;
    repeat (5) @(posedge clk);
    rst <= 0;

    dir_q.push_back(mk(OP_ADD, MAXV, MINV, ONE, 0, 1, -1, ONE));
    dir_q.push_back(mk(OP_ADD, MAXV, MINV, -1, ONE, MAXV, MINV, 0));
    dir_q.push_back(mk(OP_SUB, MINV, MAXV, 0, 0, 1, -1, MINV));
    dir_q.push_back(mk(OP_SUB, MAXV, 5, 0, 0, MINV, 5, MAXV));
    dir_q.push_back(mk(OP_DOT, ONE, 2 * ONE, 3 * ONE, 0, ONE, ONE, ONE));
    dir_q.push_back(mk(OP_DOT, MINV, MINV, MINV, 0, MINV, MINV, MINV));
    dir_q.push_back(mk(OP_DOT, MAXV, MINV, 1, 0, MINV, MAXV, 32'h8000));
    dir_q.push_back(mk(OP_DOT, 1, 1, 1, 0, 32'h7fff, 32'h8000, -32'sh8000));
    dir_q.push_back(mk(OP_CROSS, ONE, 0, 0, 0, 0, ONE, 0));
    dir_q.push_back(mk(OP_CROSS, MINV, MAXV, MINV, 0, MAXV, MINV, MAXV));
    dir_q.push_back(mk(OP_EQUAL, 7, -7, MINV, 0, 7, -7, MINV));
    dir_q.push_back(mk(OP_EQUAL, 7, -7, MINV, 0, 7, -7, MAXV));
    dir_q.push_back(mk(OP_LENGTH, 3 * ONE, 4 * ONE, 0, ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_LENGTH, ONE, ONE, ONE, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_LENGTH, 0, 0, 0, ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_LENGTH, MAXV, MAXV, MINV, 1, 0, 0, 0));
    dir_q.push_back(mk(OP_LENGTH, MAXV, MAXV, MINV, ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_NORM, 3 * ONE, 0, 4 * ONE, ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_NORM, 0, 0, 0, ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_NORM, 1, 0, 0, MAXV, 0, 0, 0));
    dir_q.push_back(mk(OP_NORM, MAXV, MINV, 0, -1, 0, 0, 0));
    dir_q.push_back(mk(OP_NORM, 5, 5, 5, 0, 0, 0, 0));
    dir_q.push_back(mk(OP_DEHOM, 2 * ONE, -4 * ONE, MINV, 2 * ONE, 0, 0, 0));
    dir_q.push_back(mk(OP_DEHOM, MINV, MAXV, 1, MINV, 0, 0, 0));
    dir_q.push_back(mk(OP_DEHOM, MINV, MAXV, 1, -1, 0, 0, 0));
    foreach (dir_q[i]) send_vec(dir_q[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 76 : 0;
      recv_idle_pct = (ph == 0) ? 76 : (ph == 1) ? 30 : 0;
      for (int i = 0; i < 610; i++) begin
        if (ph == 2 && i == 100) recv_hold = 400;
        if (ph == 2 && i == 400) begin
          // drain the pipe completely before going on
          req_valid <= 0;
          while (sb.expected_q.size() != 0) @(posedge clk);
        end
        send_vec(rand_req());
      end
    end
    req_valid <= 0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
    if (sb.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule

[files.f]
hw/rtl/vha_pkg.sv
hw/rtl/vha_div.sv
hw/rtl/vha_isqrt.sv
hw/rtl/vec3_homogeneous_alu_unit.sv
tb/testbench.sv
